>>> rtl/assert_macros.svh
// Assertion macros shared by the RTL of the bounded stack.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle check");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle check");

`endif

>>> rtl/bsws_pkg.sv
// Package for the bounded stack with search: sizes, operation and status codes,
// and the sequencer state type. No dependencies.
`default_nettype none

package bsws_pkg;

   localparam int DEPTH   = 8;
   localparam int WORD_W  = 32;
   localparam int OP_W    = 2;
   localparam int STAT_W  = 2;
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   typedef enum logic [OP_W-1:0] {
      OP_PUSH   = 2'd0,
      OP_POP    = 2'd1,
      OP_DUMP   = 2'd2,
      OP_SEARCH = 2'd3
   } op_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK       = 2'd0,
      STAT_OVERFLOW = 2'd1,
      STAT_EMPTY    = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FETCH,
      ST_SCAN,
      ST_RESP
   } state_type;

endpackage

`default_nettype wire

>>> rtl/bounded_stack_with_search.sv
// Bounded LIFO stack of signed 32-bit words with dump and search.
// A request transaction (req_valid/req_ready) carries req_operation (push,
// pop, dump, search) and req_value (word to push or key to search). Each
// request produces one or more response transactions on the rsp_ channel;
// rsp_last marks the final one. Only a dump of a non-empty stack produces
// several responses, one per stored word, top first.
// The block takes one request at a time: req_ready is high only while the
// sequencer is idle and returns in the cycle after the last response is taken.
// A push, and any request on an empty stack, is answered in the cycle after
// acceptance; a pop passes through FETCH and SCAN before its response. Search
// walks the words from the top through the registered read port and the
// comparator, in a FETCH and a SCAN step per word, until a hit or the bottom.
// Dump passes through FETCH, SCAN and RESP for each word.
// A stalled receiver holds the response register and the sequencer waits.
// Reset (synchronous, active high) empties the stack and idles the sequencer;
// stored words are not cleared, but no response returns an unwritten word.
// Depends on bsws_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module bounded_stack_with_search (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [bsws_pkg::OP_W-1:0]           req_operation,
   input  logic signed [bsws_pkg::WORD_W-1:0]  req_value,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [bsws_pkg::STAT_W-1:0]         rsp_status,
   output logic signed [bsws_pkg::WORD_W-1:0]  rsp_data,
   output logic                                rsp_found,
   output logic                                rsp_last
);
   import bsws_pkg::*;

   // Sequencer state and control registers.
   state_type              state_ff, state_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [PTR_W-1:0]       idx_ff, idx_in;
   op_type                 op_ff, op_in;
   logic [WORD_W-1:0]      key_ff, key_in;

   // Response register.
   status_type             status_ff, status_in;
   logic [WORD_W-1:0]      data_ff, data_in;
   logic                   found_ff, found_in;
   logic                   last_ff, last_in;
   logic                   rsp_load;

   // Word storage with one write port and one registered read port.
   logic [WORD_W-1:0]      mem [DEPTH];
   logic [WORD_W-1:0]      rd_data_ff;
   logic                   mem_we;

   logic                   req_fire;
   logic                   stack_empty;
   logic                   stack_full;
   logic                   hit;
   logic                   idx_zero;
   logic [CNT_W-1:0]       count_dec;
   op_type                 req_op;

   // Terms used only by the checks at the end.
   logic                   push_ok;
   logic                   search_rsp;

   assign req_fire    = req_valid && req_ready;
   assign req_op      = op_type'(req_operation);
   assign stack_empty = (count_ff == '0);
   assign stack_full  = (count_ff == CNT_W'(DEPTH));
   assign count_dec   = count_ff - CNT_W'(1);
   assign hit         = (rd_data_ff == key_ff);
   assign idx_zero    = (idx_ff == '0);

   assign req_ready  = (state_ff == ST_IDLE);
   assign rsp_valid  = (state_ff == ST_RESP);
   assign rsp_status = status_ff;
   assign rsp_data   = data_ff;
   assign rsp_found  = found_ff;
   assign rsp_last   = last_ff;

   assign push_ok    = req_fire && req_op == OP_PUSH && !stack_full;
   assign search_rsp = status_ff == STAT_OK && data_ff == '0 && op_ff == OP_SEARCH;

   // Next-state logic of the sequencer.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_op != OP_PUSH && !stack_empty) begin
                  state_in = ST_FETCH;
               end else begin
                  state_in = ST_RESP;
               end
            end
         end
         ST_FETCH: begin
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (op_ff == OP_SEARCH && !hit && !idx_zero) begin
               state_in = ST_FETCH;
            end else begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (rsp_ready) begin
               if (op_ff == OP_DUMP && !last_ff) begin
                  state_in = ST_FETCH;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Datapath control: pointer, count, memory write and response values.
   always_comb begin
      count_in  = count_ff;
      idx_in    = idx_ff;
      op_in     = op_ff;
      key_in    = key_ff;
      mem_we    = 1'b0;
      rsp_load  = 1'b0;
      status_in = STAT_OK;
      data_in   = '0;
      found_in  = 1'b0;
      last_in   = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_in  = req_op;
               key_in = req_value;
               idx_in = count_dec[PTR_W-1:0];
               if (req_op == OP_PUSH) begin
                  rsp_load = 1'b1;
                  if (stack_full) begin
                     status_in = STAT_OVERFLOW;
                  end else begin
                     mem_we   = 1'b1;
                     count_in = count_ff + CNT_W'(1);
                  end
               end else if (stack_empty) begin
                  rsp_load  = 1'b1;
                  status_in = STAT_EMPTY;
               end
            end
         end
         ST_SCAN: begin
            case (op_ff)
               OP_POP: begin
                  rsp_load = 1'b1;
                  data_in  = rd_data_ff;
                  count_in = count_dec;
               end
               OP_DUMP: begin
                  rsp_load = 1'b1;
                  data_in  = rd_data_ff;
                  last_in  = idx_zero;
               end
               OP_SEARCH: begin
                  if (hit || idx_zero) begin
                     rsp_load = 1'b1;
                     found_in = hit;
                  end else begin
                     idx_in = idx_ff - PTR_W'(1);
                  end
               end
               default: begin
                  rsp_load = 1'b0;
               end
            endcase
         end
         ST_RESP: begin
            // Step down to the next word of a dump once this one is taken.
            if (rsp_ready && op_ff == OP_DUMP && !last_ff) begin
               idx_in = idx_ff - PTR_W'(1);
            end
         end
         default: begin
            rsp_load = 1'b0;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   // Payload registers need no reset.
   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      op_ff  <= op_in;
      key_ff <= key_in;
      if (rsp_load) begin
         status_ff <= status_in;
         data_ff   <= data_in;
         found_ff  <= found_in;
         last_ff   <= last_in;
      end
   end

   // Storage: written on push, read every cycle at the scan pointer.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[count_ff[PTR_W-1:0]] <= req_value;
      end
      rd_data_ff <= mem[idx_ff];
   end

   // Checks on the sequencer and datapath.
   `ASSERT_SAME(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(DEPTH))
   `ASSERT_SAME(a_one_side, clock, reset, rsp_valid, !req_ready)
   `ASSERT_NEXT(a_push_grows, clock, reset, push_ok, count_ff == $past(count_ff) + CNT_W'(1))
   `ASSERT_SAME(a_found_ok, clock, reset, rsp_valid && rsp_found, search_rsp)

endmodule

`default_nettype wire
